[src/bletlv_pkg.sv]
// Shared types and codes for the advertising-data TLV parser.
// No dependencies; used by bletlv_step and ble_adv_data_tlv_parser_core.
`default_nettype none

package bletlv_pkg;

    // Parser phase within one packet
    typedef enum logic [1:0] {
        PH_LEN  = 2'd0,
        PH_TYPE = 2'd1,
        PH_PAY  = 2'd2,
        PH_SKIP = 2'd3
    } t_phase;

    // Byte role codes on the result
    localparam logic [1:0] ROLE_LEN  = 2'd0;
    localparam logic [1:0] ROLE_TYPE = 2'd1;
    localparam logic [1:0] ROLE_PAY  = 2'd2;
    localparam logic [1:0] ROLE_SKIP = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_ZERO    = 2'd1;
    localparam logic [1:0] ST_OVERRUN = 2'd2;
    localparam logic [1:0] ST_LONE    = 2'd3;

    // Parser state carried from byte to byte
    typedef struct packed {
        t_phase     phase;
        logic [7:0] bytes_left;
        logic [7:0] cur_type;
        logic [7:0] payload_pos;
        logic [1:0] err_code;
    } t_state;

    localparam t_state STATE_RESET = '{
        phase:       PH_LEN,
        bytes_left:  8'd0,
        cur_type:    8'd0,
        payload_pos: 8'd0,
        err_code:    ST_OK
    };

    // One result (payload byte and packet end travel separately)
    typedef struct packed {
        logic [1:0] byte_role;
        logic [7:0] ad_type;
        logic [7:0] payload_index;
        logic       field_end;
        logic [1:0] status;
    } t_result;

endpackage

`default_nettype wire

[src/bletlv_step.sv]
// Per-byte parse step: next parser state and result fields for one byte.
// Depends on bletlv_pkg.
`default_nettype none

module bletlv_step (
    input  wire bletlv_pkg::t_state  i_state,
    input  wire logic [7:0]          i_data_byte,
    input  wire logic                i_last_byte,
    output bletlv_pkg::t_state       o_state,
    output bletlv_pkg::t_result      o_result
);

    logic [7:0] left_dec;
    bletlv_pkg::t_state st;

    assign left_dec = i_state.bytes_left - 8'd1;

    // Decode byte by phase
    always_comb begin
        st       = i_state;
        o_result = '{
            byte_role:     bletlv_pkg::ROLE_LEN,
            ad_type:       8'd0,
            payload_index: 8'd0,
            field_end:     1'b0,
            status:        bletlv_pkg::ST_OK
        };
        case (i_state.phase)
            bletlv_pkg::PH_LEN: begin
                o_result.byte_role = bletlv_pkg::ROLE_LEN;
                if (i_last_byte) begin
                    o_result.status = bletlv_pkg::ST_LONE;
                end else if (i_data_byte == 8'd0) begin
                    st.err_code     = bletlv_pkg::ST_ZERO;
                    o_result.status = bletlv_pkg::ST_ZERO;
                    st.phase        = bletlv_pkg::PH_SKIP;
                end else begin
                    st.bytes_left  = i_data_byte;
                    st.payload_pos = 8'd0;
                    st.phase       = bletlv_pkg::PH_TYPE;
                end
            end
            bletlv_pkg::PH_TYPE: begin
                o_result.byte_role = bletlv_pkg::ROLE_TYPE;
                o_result.ad_type   = i_data_byte;
                st.cur_type        = i_data_byte;
                st.bytes_left      = left_dec;
                if (left_dec == 8'd0) begin
                    o_result.field_end = 1'b1;
                    st.phase           = bletlv_pkg::PH_LEN;
                end else begin
                    st.phase = bletlv_pkg::PH_PAY;
                    if (i_last_byte) begin
                        o_result.status = bletlv_pkg::ST_OVERRUN;
                    end
                end
            end
            bletlv_pkg::PH_PAY: begin
                o_result.byte_role     = bletlv_pkg::ROLE_PAY;
                o_result.ad_type       = i_state.cur_type;
                o_result.payload_index = i_state.payload_pos;
                st.payload_pos         = i_state.payload_pos + 8'd1;
                st.bytes_left          = left_dec;
                if (left_dec == 8'd0) begin
                    o_result.field_end = 1'b1;
                    st.phase           = bletlv_pkg::PH_LEN;
                end else if (i_last_byte) begin
                    o_result.status = bletlv_pkg::ST_OVERRUN;
                end
            end
            default: begin
                o_result.byte_role = bletlv_pkg::ROLE_SKIP;
                o_result.status    = i_state.err_code;
            end
        endcase
    end

    // Packet end returns the parser to its reset state
    assign o_state = i_last_byte ? bletlv_pkg::STATE_RESET : st;

endmodule

`default_nettype wire

[src/ble_adv_data_tlv_parser_core.sv]
// BLE advertising-data TLV parser, top level: input register, parse step, result register.
// Depends on bletlv_pkg and bletlv_step.
//
//  Channel | Direction | Handshake               | Payload
//  --------+-----------+-------------------------+------------------------------------------
//  in      | input     | i_in_valid / o_in_stall | i_data_byte, i_last_byte
//  out     | output    | o_out_valid / i_out_stall | o_byte_role, o_ad_type, o_payload_index,
//          |           |                         | o_payload_byte, o_field_end, o_packet_end,
//          |           |                         | o_status
//
// One request per cycle unless the output stalls; stages: input register, result register.
// The parse step is one combinational pass between those registers, updating the state.
// Synchronous active-low reset clears valids and parser state.
// A stall on a valid result holds the result stage and a full input stage; o_in_stall rises
// only while the input stage is full and cannot advance.
`default_nettype none

module ble_adv_data_tlv_parser_core (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_last_byte,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [1:0]      o_byte_role,
    output logic [7:0]      o_ad_type,
    output logic [7:0]      o_payload_index,
    output logic [7:0]      o_payload_byte,
    output logic            o_field_end,
    output logic            o_packet_end,
    output logic [1:0]      o_status
);

    logic                  r_in_valid;
    logic [7:0]            r_in_byte;
    logic                  r_in_last;
    logic                  r_out_valid;
    bletlv_pkg::t_result   r_result;
    logic [7:0]            r_out_byte;
    logic                  r_out_last;
    bletlv_pkg::t_state    r_state;
    bletlv_pkg::t_state    n_state;
    bletlv_pkg::t_result   n_result;
    logic                  adv;
    logic                  in_take;

    // Pipeline advance: result slot is free or being drained
    assign adv        = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !adv;
    assign in_take    = i_in_valid && !o_in_stall;

    // Input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
        end
    end

    bletlv_step u_step (
        .i_state     (r_state),
        .i_data_byte (r_in_byte),
        .i_last_byte (r_in_last),
        .o_state     (n_state),
        .o_result    (n_result)
    );

    // Parser state moves when a byte passes to the result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bletlv_pkg::STATE_RESET;
        end else if (r_in_valid && adv) begin
            r_state <= n_state;
        end
    end

    // Result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_in_valid) begin
            r_result   <= n_result;
            r_out_byte <= r_in_byte;
            r_out_last <= r_in_last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_byte_role     = r_result.byte_role;
    assign o_ad_type       = r_result.ad_type;
    assign o_payload_index = r_result.payload_index;
    assign o_payload_byte  = r_out_byte;
    assign o_field_end     = r_result.field_end;
    assign o_packet_end    = r_out_last;
    assign o_status        = r_result.status;

endmodule

`default_nettype wire
